@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the checker file of the ramp and slew block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a clock, disabled while the active-low reset is low.
`define PRS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("parameter ramp slew assertion failed");

// Condition that must hold in the cycle after a trigger.
`define PRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    `PRS_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))

`endif

@@ sv/prs_pkg.sv @@
// ----------------------------------------------------------------------------
// prs_pkg
// Types and constants shared by the controller and datapath of the
// parameter ramp and slew unit.
// ----------------------------------------------------------------------------
package prs_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int COUNT_WIDTH_DEF = 24;

    typedef enum logic [1:0] {
        REQ_SET  = 2'd0,
        REQ_RAMP = 2'd1,
        REQ_SLEW = 2'd2,
        REQ_TICK = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_RAMP = 2'd1,
        MODE_SLEW = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DIV_START,
        S_DIV_WAIT,
        S_DIV_FIX,
        S_RAMP_ACC,
        S_RAMP_LEVEL,
        S_SLEW_DIFF,
        S_SLEW_STEP,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic capture;
        logic do_set;
        logic ramp_begin;
        logic div_start;
        logic div_fix;
        logic ramp_acc;
        logic ramp_level;
        logic slew_begin;
        logic slew_diff;
        logic slew_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_req  req;
        logic  count_zero;
        logic  target_eq_level;
        t_mode mode;
        logic  div_done;
    } t_status;

endpackage

@@ sv/prs_div.sv @@
// ----------------------------------------------------------------------------
// prs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module prs_div #(
    parameter int DIVIDEND_WIDTH = prs_pkg::VALUE_WIDTH_DEF,
    parameter int DIVISOR_WIDTH  = prs_pkg::COUNT_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [DIVIDEND_WIDTH-1:0] i_dividend,
    input  logic [DIVISOR_WIDTH-1:0]  i_divisor,
    output logic                      o_done,
    output logic [DIVIDEND_WIDTH-1:0] o_quotient,
    output logic [DIVISOR_WIDTH-1:0]  o_remainder
);

    localparam int CNT_W = $clog2(DIVIDEND_WIDTH + 1);

    logic                      r_busy;
    logic                      r_done;
    logic [CNT_W-1:0]          r_cnt;
    logic [DIVIDEND_WIDTH-1:0] r_quot;
    logic [DIVISOR_WIDTH-1:0]  r_rem;

    logic [DIVISOR_WIDTH:0]    w_trial;
    logic [DIVISOR_WIDTH:0]    w_diff;
    logic                      w_fits;

    always_comb begin
        w_trial = {r_rem, r_quot[DIVIDEND_WIDTH-1]};
        w_fits  = (w_trial >= {1'b0, i_divisor});
        w_diff  = w_trial - {1'b0, i_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIVIDEND_WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_quot <= {r_quot[DIVIDEND_WIDTH-2:0], w_fits};
            r_rem  <= w_fits ? w_diff[DIVISOR_WIDTH-1:0] : w_trial[DIVISOR_WIDTH-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quot;
    assign o_remainder = r_rem;

endmodule

@@ sv/prs_dp.sv @@
// ----------------------------------------------------------------------------
// prs_dp
// Datapath: request capture, level and motion registers, incremental ramp
// accumulator, slew stepping and the result register.
// ----------------------------------------------------------------------------
module prs_dp #(
    parameter int VALUE_WIDTH = prs_pkg::VALUE_WIDTH_DEF,
    parameter int COUNT_WIDTH = prs_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  prs_pkg::t_cmd                 i_cmd,
    input  logic [1:0]                    i_req_type,
    input  logic signed [VALUE_WIDTH-1:0] i_target_value,
    input  logic [COUNT_WIDTH-1:0]        i_sample_count,
    input  logic signed [VALUE_WIDTH-1:0] i_step_size,
    output prs_pkg::t_status              o_status,
    output logic signed [VALUE_WIDTH-1:0] o_out_value,
    output logic                          o_moving
);

    localparam int VW = VALUE_WIDTH;
    localparam int CW = COUNT_WIDTH;
    localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

    // Captured request
    prs_pkg::t_req r_req;
    logic [VW-1:0] r_target;
    logic [CW-1:0] r_count;
    logic [VW-1:0] r_step_in;

    // Motion state
    prs_pkg::t_mode r_mode;
    logic [VW-1:0]  r_level;
    logic [VW-1:0]  r_origin;
    logic [VW:0]    r_span;
    logic [CW-1:0]  r_length;
    logic [CW:0]    r_pos;
    logic [VW:0]    r_qs;
    logic [CW-1:0]  r_rs;
    logic [VW:0]    r_acc_q;
    logic [CW-1:0]  r_acc_r;
    logic [VW-1:0]  r_goal;
    logic [VW-1:0]  r_step;
    logic [VW-1:0]  r_step_mag;
    logic [VW:0]    r_diff;

    logic [VW-1:0]  r_out_value;
    logic           r_out_moving;

    // Divider
    logic           w_div_done;
    logic [VW-1:0]  w_quot;
    logic [CW-1:0]  w_rem;
    logic [VW:0]    w_span_abs;

    logic [CW:0]    w_rsum;
    logic           w_r_wrap;
    logic [VW+1:0]  w_ramp_sum;
    logic [VW-1:0]  w_ramp_level;
    logic [VW-1:0]  w_mag;
    logic [VW-1:0]  w_up_mag;
    logic           w_up;
    logic [VW:0]    w_neg_sum;
    logic           w_close;
    logic [VW:0]    w_slew_sum;
    logic [VW-1:0]  w_slew_level;

    always_comb begin
        w_span_abs = r_span[VW] ? (~r_span + 1'b1) : r_span;
    end

    prs_div #(
        .DIVIDEND_WIDTH (VW),
        .DIVISOR_WIDTH  (CW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (w_span_abs[VW-1:0]),
        .i_divisor   (r_length),
        .o_done      (w_div_done),
        .o_quotient  (w_quot),
        .o_remainder (w_rem)
    );

    // Ramp: span*k = acc_q*N + acc_r is advanced by span = qs*N + rs each tick.
    always_comb begin
        w_rsum     = {1'b0, r_acc_r} + {1'b0, r_rs};
        w_r_wrap   = (w_rsum >= {1'b0, r_length});
        w_ramp_sum = {{2{r_origin[VW-1]}}, r_origin} + {r_acc_q[VW], r_acc_q};
        if (w_ramp_sum[VW+1:VW-1] == 3'b000 || w_ramp_sum[VW+1:VW-1] == 3'b111) begin
            w_ramp_level = w_ramp_sum[VW-1:0];
        end else begin
            w_ramp_level = w_ramp_sum[VW+1] ? VMIN : VMAX;
        end
    end

    // Slew setup and stepping.
    always_comb begin
        w_mag    = r_step_in[VW-1] ? (~r_step_in + 1'b1) : r_step_in;
        w_up_mag = w_mag[VW-1] ? VMAX : w_mag;
        w_up     = ($signed(r_target) > $signed(r_level));
        // A negative distance is closer than the step when distance + step > 0.
        w_neg_sum = r_diff + {1'b0, r_step_mag};
        if (!r_diff[VW]) begin
            w_close = (r_diff < {1'b0, r_step_mag});
        end else begin
            w_close = !w_neg_sum[VW] && (w_neg_sum != '0);
        end
        w_slew_sum = {r_level[VW-1], r_level} + {r_step[VW-1], r_step};
        if (w_slew_sum[VW] != w_slew_sum[VW-1]) begin
            w_slew_level = w_slew_sum[VW] ? VMIN : VMAX;
        end else begin
            w_slew_level = w_slew_sum[VW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= prs_pkg::MODE_OFF;
            r_level <= '0;
        end else begin
            if (i_cmd.do_set) begin
                r_level <= r_target;
                r_mode  <= prs_pkg::MODE_OFF;
            end
            if (i_cmd.ramp_begin) begin
                r_mode <= prs_pkg::MODE_RAMP;
            end
            if (i_cmd.slew_begin) begin
                r_mode <= prs_pkg::MODE_SLEW;
            end
            if (i_cmd.ramp_acc && r_pos >= {1'b0, r_length}) begin
                r_mode <= prs_pkg::MODE_OFF;
            end
            if (i_cmd.ramp_level) begin
                r_level <= w_ramp_level;
            end
            if (i_cmd.slew_step) begin
                if (w_close) begin
                    r_level <= r_goal;
                    r_mode  <= prs_pkg::MODE_OFF;
                end else begin
                    r_level <= w_slew_level;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req     <= prs_pkg::t_req'(i_req_type);
            r_target  <= i_target_value;
            r_count   <= i_sample_count;
            r_step_in <= i_step_size;
        end
        if (i_cmd.ramp_begin) begin
            r_origin <= r_level;
            r_span   <= {r_target[VW-1], r_target} - {r_level[VW-1], r_level};
            r_length <= r_count;
            r_pos    <= {{CW{1'b0}}, 1'b1};
            r_acc_q  <= '0;
            r_acc_r  <= '0;
        end
        // Floor division of a negative span: quotient down by one, remainder
        // reflected, unless the division is exact.
        if (i_cmd.div_fix) begin
            if (!r_span[VW]) begin
                r_qs <= {1'b0, w_quot};
                r_rs <= w_rem;
            end else if (w_rem == '0) begin
                r_qs <= ~{1'b0, w_quot} + 1'b1;
                r_rs <= '0;
            end else begin
                r_qs <= ~{1'b0, w_quot};
                r_rs <= r_length - w_rem;
            end
        end
        if (i_cmd.ramp_acc) begin
            r_acc_r <= w_r_wrap ? (w_rsum[CW-1:0] - r_length) : w_rsum[CW-1:0];
            r_acc_q <= r_acc_q + r_qs + {{VW{1'b0}}, w_r_wrap};
            r_pos   <= r_pos + 1'b1;
        end
        if (i_cmd.slew_begin) begin
            r_goal     <= r_target;
            r_step_mag <= w_up ? w_up_mag : w_mag;
            r_step     <= w_up ? w_up_mag : (~w_mag + 1'b1);
        end
        if (i_cmd.slew_diff) begin
            r_diff <= {r_goal[VW-1], r_goal} - {r_level[VW-1], r_level};
        end
        if (i_cmd.out_load) begin
            r_out_value  <= r_level;
            r_out_moving <= (r_mode != prs_pkg::MODE_OFF);
        end
    end

    always_comb begin
        o_status.req             = r_req;
        o_status.count_zero      = (r_count == '0);
        o_status.target_eq_level = (r_target == r_level);
        o_status.mode            = r_mode;
        o_status.div_done        = w_div_done;
    end

    assign o_out_value = r_out_value;
    assign o_moving    = r_out_moving;

endmodule

@@ sv/prs_ctrl.sv @@
// ----------------------------------------------------------------------------
// prs_ctrl
// Controller: sequences each request through the datapath and owns both
// channel handshakes.
// ----------------------------------------------------------------------------
module prs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  prs_pkg::t_status i_status,
    output prs_pkg::t_cmd    o_cmd
);

    prs_pkg::t_state r_state;
    prs_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= prs_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            prs_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = prs_pkg::S_DECODE;
                end
            end
            prs_pkg::S_DECODE: begin
                case (i_status.req)
                    prs_pkg::REQ_SET: begin
                        o_cmd.do_set = 1'b1;
                        n_state      = prs_pkg::S_FINISH;
                    end
                    prs_pkg::REQ_RAMP: begin
                        if (i_status.count_zero) begin
                            o_cmd.do_set = 1'b1;
                            n_state      = prs_pkg::S_FINISH;
                        end else begin
                            o_cmd.ramp_begin = 1'b1;
                            n_state          = prs_pkg::S_DIV_START;
                        end
                    end
                    prs_pkg::REQ_SLEW: begin
                        if (i_status.target_eq_level) begin
                            o_cmd.do_set = 1'b1;
                        end else begin
                            o_cmd.slew_begin = 1'b1;
                        end
                        n_state = prs_pkg::S_FINISH;
                    end
                    prs_pkg::REQ_TICK: begin
                        case (i_status.mode)
                            prs_pkg::MODE_RAMP: n_state = prs_pkg::S_RAMP_ACC;
                            prs_pkg::MODE_SLEW: n_state = prs_pkg::S_SLEW_DIFF;
                            default:            n_state = prs_pkg::S_FINISH;
                        endcase
                    end
                    default: n_state = prs_pkg::S_FINISH;
                endcase
            end
            prs_pkg::S_DIV_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = prs_pkg::S_DIV_WAIT;
            end
            prs_pkg::S_DIV_WAIT: begin
                if (i_status.div_done) begin
                    n_state = prs_pkg::S_DIV_FIX;
                end
            end
            prs_pkg::S_DIV_FIX: begin
                o_cmd.div_fix = 1'b1;
                n_state       = prs_pkg::S_FINISH;
            end
            prs_pkg::S_RAMP_ACC: begin
                o_cmd.ramp_acc = 1'b1;
                n_state        = prs_pkg::S_RAMP_LEVEL;
            end
            prs_pkg::S_RAMP_LEVEL: begin
                o_cmd.ramp_level = 1'b1;
                n_state          = prs_pkg::S_FINISH;
            end
            prs_pkg::S_SLEW_DIFF: begin
                o_cmd.slew_diff = 1'b1;
                n_state         = prs_pkg::S_SLEW_STEP;
            end
            prs_pkg::S_SLEW_STEP: begin
                o_cmd.slew_step = 1'b1;
                n_state         = prs_pkg::S_FINISH;
            end
            prs_pkg::S_FINISH: begin
                // The result register is loaded once the previous item has left or is taken in this cycle.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = prs_pkg::S_IDLE;
                end
            end
            default: n_state = prs_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ sv/parameter_ramp_slew_unit.sv @@
// ----------------------------------------------------------------------------
// parameter_ramp_slew_unit
// Smoothed Q16.16 control value with set, linear ramp, slew and tick requests.
//
//   channel  direction  handshake                  payload
//   request  in         i_in_valid / o_in_ready    req_type, target_value,
//                                                  sample_count, step_size
//   result   out        o_out_valid / i_out_ready  out_value, moving
//
// One request is processed at a time. A ramp start waits for the bit-serial
// divider that splits the span by the ramp length. Reset is synchronous; it
// clears the level to zero and stops any motion. A new request is taken
// while the previous result waits; a stalled result holds the finishing
// request, and with it the input.
// ----------------------------------------------------------------------------
module parameter_ramp_slew_unit #(
    parameter int VALUE_WIDTH = prs_pkg::VALUE_WIDTH_DEF,
    parameter int COUNT_WIDTH = prs_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_req_type,
    input  logic signed [VALUE_WIDTH-1:0] i_target_value,
    input  logic [COUNT_WIDTH-1:0]        i_sample_count,
    input  logic signed [VALUE_WIDTH-1:0] i_step_size,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [VALUE_WIDTH-1:0] o_out_value,
    output logic                          o_moving
);

    prs_pkg::t_cmd    w_cmd;
    prs_pkg::t_status w_status;

    prs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    prs_dp #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_req_type     (i_req_type),
        .i_target_value (i_target_value),
        .i_sample_count (i_sample_count),
        .i_step_size    (i_step_size),
        .o_status       (w_status),
        .o_out_value    (o_out_value),
        .o_moving       (o_moving)
    );

endmodule

@@ sv/prs_checker.sv @@
// ----------------------------------------------------------------------------
// prs_checker
// Port-level checks for the parameter ramp and slew unit, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prs_checker #(
    parameter int VALUE_WIDTH = prs_pkg::VALUE_WIDTH_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic signed [VALUE_WIDTH-1:0] o_out_value,
    input logic                          o_moving
);

    // A stalled result holds its value.
    `PRS_ASSERT_NEXT(a_result_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_value) && $stable(o_moving))

    // An accepted item keeps the block busy for at least the next cycle.
    `PRS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // Every return to idle delivers a result.
    `PRS_ASSERT(a_idle_has_result, i_clk, i_rst_n, $rose(o_in_ready) && $past(i_rst_n) |-> o_out_valid)

    // A new result only appears at the end of work on an item.
    `PRS_ASSERT(a_result_from_work, i_clk, i_rst_n, $rose(o_out_valid) && $past(i_rst_n) |-> $past(!o_in_ready))

endmodule

bind parameter_ramp_slew_unit prs_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_prs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_value (o_out_value),
    .o_moving    (o_moving)
);

@@ verif/parameter_ramp_slew_unit_tb.sv @@
// ----------------------------------------------------------------------------
// parameter_ramp_slew_unit_tb
// Self-checking bench for the ramp and slew control value unit. A directed
// list covers the value extremes, zero-length ramps, slews to the current
// level, step saturation, zero steps and idle ticks. It is followed by random
// set, ramp and slew requests, each trailed by a run of ticks. Results are
// checked by a behavioral predictor; later phases idle the handshakes randomly.
// ----------------------------------------------------------------------------
module parameter_ramp_slew_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW = prs_pkg::VALUE_WIDTH_DEF;
    localparam int CW = prs_pkg::COUNT_WIDTH_DEF;
    localparam longint LEVEL_MAX = (64'sd1 <<< (VW - 1)) - 1;
    localparam longint LEVEL_MIN = -LEVEL_MAX - 1;

    typedef struct {
        logic signed [VW-1:0] value;
        logic                 moving;
    } t_level_result;

    typedef struct {
        prs_pkg::t_req        req;
        logic signed [VW-1:0] target;
        logic [CW-1:0]        count;
        logic signed [VW-1:0] step;
        bit                   typed;
        logic signed [VW-1:0] exp_value;
        bit                   exp_moving;
    } t_stim_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [1:0]           i_req_type;
    logic signed [VW-1:0] i_target_value;
    logic [CW-1:0]        i_sample_count;
    logic signed [VW-1:0] i_step_size;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic signed [VW-1:0] o_out_value;
    logic                 o_moving;

    // Predicted state of the control value.
    logic signed [VW-1:0] cur_level;
    logic signed [VW-1:0] ramp_origin;
    logic signed [VW:0]   ramp_span;
    logic [CW-1:0]        ramp_len;
    logic [CW:0]          ramp_pos;
    logic signed [VW-1:0] slew_target;
    logic signed [VW-1:0] slew_inc;
    prs_pkg::t_mode       motion;

    t_level_result pending_levels[$];
    t_level_result head_level;
    t_stim_row     stim_rows[$];
    int            error_count;
    int            idle_pct;
    int            stall_pct;
    int            drain_cycles;

    parameter_ramp_slew_unit #(
        .VALUE_WIDTH(VW),
        .COUNT_WIDTH(CW)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_target_value(i_target_value),
        .i_sample_count(i_sample_count),
        .i_step_size   (i_step_size),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_value   (o_out_value),
        .o_moving      (o_moving)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic signed [VW-1:0] clamp_level(input longint v);
        if (v > LEVEL_MAX) return VW'(LEVEL_MAX);
        if (v < LEVEL_MIN) return VW'(LEVEL_MIN);
        return VW'(v);
    endfunction

    task automatic hold_level(input logic signed [VW-1:0] v);
        cur_level = v;
        motion = prs_pkg::MODE_OFF;
        ramp_origin = '0;
        ramp_span = '0;
        ramp_len = '0;
        ramp_pos = '0;
        slew_inc = '0;
    endtask

    task automatic advance_level(input prs_pkg::t_req r, input logic signed [VW-1:0] tv,
                                 input logic [CW-1:0] cnt,
                                 input logic signed [VW-1:0] st);
        longint mag;
        longint gap;
        longint k;
        longint n;
        longint q;
        longint rem;
        case (r)
            prs_pkg::REQ_SET: begin
                hold_level(tv);
            end
            prs_pkg::REQ_RAMP: begin
                if (cnt == 0) begin
                    hold_level(tv);
                end else begin
                    ramp_origin = cur_level;
                    ramp_span = (VW+1)'(longint'(tv) - longint'(cur_level));
                    ramp_len = cnt;
                    ramp_pos = (CW+1)'(1);
                    motion = prs_pkg::MODE_RAMP;
                end
            end
            prs_pkg::REQ_SLEW: begin
                if (tv == cur_level) begin
                    hold_level(tv);
                end else begin
                    mag = (st < 0) ? -longint'(st) : longint'(st);
                    motion = prs_pkg::MODE_SLEW;
                    slew_target = tv;
                    // Upward steps saturate, so the most negative step still moves up.
                    if (tv > cur_level) slew_inc = (mag > LEVEL_MAX) ? VW'(LEVEL_MAX) : VW'(mag);
                    else slew_inc = VW'(-mag);
                end
            end
            default: begin
                if (motion == prs_pkg::MODE_RAMP) begin
                    k = longint'(ramp_pos);
                    n = longint'(ramp_len);
                    if (n == 0) begin
                        motion = prs_pkg::MODE_OFF;
                    end else begin
                        if (k > n) k = n;
                        // Floor of span * k / n, split to keep the product narrow.
                        q = longint'(ramp_span) / n;
                        rem = longint'(ramp_span) % n;
                        if (rem < 0) begin
                            rem += n;
                            q -= 1;
                        end
                        cur_level = clamp_level(longint'(ramp_origin) + q * k + (rem * k) / n);
                        if (ramp_pos >= ramp_len) motion = prs_pkg::MODE_OFF;
                        ramp_pos = ramp_pos + 1'b1;
                    end
                end else if (motion == prs_pkg::MODE_SLEW) begin
                    gap = longint'(slew_target) - longint'(cur_level);
                    if (gap < 0) gap = -gap;
                    mag = longint'(slew_inc);
                    if (mag < 0) mag = -mag;
                    if (gap < mag) begin
                        cur_level = slew_target;
                        motion = prs_pkg::MODE_OFF;
                    end else begin
                        cur_level = clamp_level(longint'(cur_level) + longint'(slew_inc));
                    end
                end
            end
        endcase
    endtask

    // Drives one item, waits for it to be taken and records its expected result.
    task automatic send_request(input prs_pkg::t_req r, input logic signed [VW-1:0] tv,
                                input logic [CW-1:0] cnt,
                                input logic signed [VW-1:0] st, input bit typed,
                                input logic signed [VW-1:0] exp_value,
                                input bit exp_moving);
        t_level_result res;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= r;
        i_target_value <= tv;
        i_sample_count <= cnt;
        i_step_size <= st;
        do @(posedge i_clk); while (!o_in_ready);
        advance_level(r, tv, cnt, st);
        if (typed) begin
            res.value = exp_value;
            res.moving = exp_moving;
        end else begin
            res.value = cur_level;
            res.moving = (motion != prs_pkg::MODE_OFF);
        end
        pending_levels.push_back(res);
    endtask

    task automatic add_row(input prs_pkg::t_req r, input logic signed [VW-1:0] tv,
                           input logic [CW-1:0] cnt, input logic signed [VW-1:0] st,
                           input bit typed, input logic signed [VW-1:0] exp_value,
                           input bit exp_moving);
        t_stim_row row;
        row.req = r;
        row.target = tv;
        row.count = cnt;
        row.step = st;
        row.typed = typed;
        row.exp_value = exp_value;
        row.exp_moving = exp_moving;
        stim_rows.push_back(row);
    endtask

    // Each request with random content is followed by a random run of ticks.
    task automatic run_random_phase(input int quota);
        int sent;
        int kind;
        int pick;
        int ticks;
        logic signed [VW-1:0] tgt;
        logic signed [VW-1:0] stp;
        logic [CW-1:0]        cnt;
        longint               gap;
        sent = 0;
        while (sent < quota) begin
            kind = $urandom_range(0, 9);
            if ($urandom_range(0, 1)) tgt = $urandom;
            else tgt = cur_level + ($signed($urandom) >>> $urandom_range(8, 28));
            case (kind)
                0, 1: begin
                    send_request(prs_pkg::REQ_SET, tgt, CW'($urandom), $urandom, 0, '0, 0);
                end
                2, 3, 4: begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0) cnt = '0;
                    else if (pick < 8) cnt = CW'($urandom_range(1, 12));
                    else cnt = CW'($urandom);
                    send_request(prs_pkg::REQ_RAMP, tgt, cnt, $urandom, 0, '0, 0);
                end
                5, 6, 7: begin
                    pick = $urandom_range(0, 9);
                    gap = longint'(tgt) - longint'(cur_level);
                    if (pick == 0) stp = '0;
                    else if (pick == 1) stp = $urandom;
                    else stp = VW'(gap / longint'($urandom_range(1, 8)));
                    if ($urandom_range(0, 1)) stp = -stp;
                    send_request(prs_pkg::REQ_SLEW, tgt, CW'($urandom), stp, 0, '0, 0);
                end
                8: begin
                    send_request(prs_pkg::t_req'($urandom_range(0, 3)), $urandom,
                                 CW'($urandom), $urandom, 0, '0, 0);
                end
                default: ;
            endcase
            if (kind < 9) sent++;
            ticks = $urandom_range(0, 12);
            repeat (ticks) send_request(prs_pkg::REQ_TICK, $urandom, CW'($urandom),
                                        $urandom, 0, '0, 0);
            sent += ticks;
        end
    endtask

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_levels.size() == 0) begin
                $error("result item with no expectation: out_value %0d, moving %0b",
                       o_out_value, o_moving);
                error_count++;
            end else begin
                head_level = pending_levels.pop_front();
                if (o_out_value !== head_level.value) begin
                    $error("out_value mismatch: expected %0d, actual %0d",
                           head_level.value, o_out_value);
                    error_count++;
                end
                if (o_moving !== head_level.moving) begin
                    $error("moving mismatch: expected %0b, actual %0b",
                           head_level.moving, o_moving);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_req_type = prs_pkg::REQ_TICK;
        i_target_value = '0;
        i_sample_count = '0;
        i_step_size = '0;
        i_out_ready = 1'b0;
        error_count = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_level('0);
        slew_target = '0;

        // Extremes, zero-length ramp, a full ramp down, the saturated upward
        // slew step, zero step, negative step moving up, and idle ticks.
        add_row(prs_pkg::REQ_TICK, 32'sh1234_5678, 24'hFFFFFF, 32'sh7FFF_FFFF, 1, 32'sh0, 0);
        add_row(prs_pkg::REQ_SET,  32'sh7FFF_FFFF, 24'h0, 32'sh0, 1, 32'sh7FFF_FFFF, 0);
        add_row(prs_pkg::REQ_SET,  32'sh8000_0000, 24'h0, 32'sh0, 1, 32'sh8000_0000, 0);
        add_row(prs_pkg::REQ_RAMP, 32'sh7FFF_FFFF, 24'h0, 32'sh0, 1, 32'sh7FFF_FFFF, 0);
        add_row(prs_pkg::REQ_RAMP, 32'sh8000_0000, 24'h4, 32'sh0, 1, 32'sh7FFF_FFFF, 1);
        add_row(prs_pkg::REQ_TICK, 32'sh0, 24'h0, 32'sh0, 0, '0, 0);
        add_row(prs_pkg::REQ_TICK, 32'sh0, 24'h0, 32'sh0, 0, '0, 0);
        add_row(prs_pkg::REQ_TICK, 32'sh0, 24'h0, 32'sh0, 0, '0, 0);
        add_row(prs_pkg::REQ_TICK, 32'sh0, 24'h0, 32'sh0, 1, 32'sh8000_0000, 0);
        add_row(prs_pkg::REQ_TICK, 32'sh0, 24'h0, 32'sh0, 1, 32'sh8000_0000, 0);
        add_row(prs_pkg::REQ_SLEW, 32'sh8000_0000, 24'h0, 32'sh0001_0000, 1,
                32'sh8000_0000, 0);
        add_row(prs_pkg::REQ_SLEW, 32'sh7FFF_FFFF, 24'h0, 32'sh8000_0000, 1,
                32'sh8000_0000, 1);
        add_row(prs_pkg::REQ_TICK, 32'sh0, 24'h0, 32'sh0, 0, '0, 0);
        add_row(prs_pkg::REQ_TICK, 32'sh0, 24'h0, 32'sh0, 0, '0, 0);
        add_row(prs_pkg::REQ_TICK, 32'sh0, 24'h0, 32'sh0, 1, 32'sh7FFF_FFFF, 0);
        add_row(prs_pkg::REQ_SLEW, 32'sh0, 24'h0, 32'sh0, 1, 32'sh7FFF_FFFF, 1);
        add_row(prs_pkg::REQ_TICK, 32'sh0, 24'h0, 32'sh0, 1, 32'sh7FFF_FFFF, 1);
        add_row(prs_pkg::REQ_RAMP, 32'sh1234_5678, 24'hFFFFFF, 32'sh0, 1, 32'sh7FFF_FFFF, 1);
        add_row(prs_pkg::REQ_TICK, 32'sh0, 24'h0, 32'sh0, 0, '0, 0);
        add_row(prs_pkg::REQ_SET,  32'sh0, 24'h0, 32'sh0, 1, 32'sh0, 0);
        add_row(prs_pkg::REQ_SLEW, 32'sh0003_0000, 24'h0, -32'sh0001_0000, 1, 32'sh0, 1);
        add_row(prs_pkg::REQ_TICK, 32'sh0, 24'h0, 32'sh0, 0, '0, 0);
        add_row(prs_pkg::REQ_TICK, 32'sh0, 24'h0, 32'sh0, 0, '0, 0);
        add_row(prs_pkg::REQ_TICK, 32'sh0, 24'h0, 32'sh0, 0, '0, 0);
        add_row(prs_pkg::REQ_TICK, 32'sh0, 24'h0, 32'sh0, 1, 32'sh0003_0000, 0);
        add_row(prs_pkg::REQ_RAMP, 32'sh5, 24'h1, 32'sh0, 1, 32'sh0003_0000, 1);
        add_row(prs_pkg::REQ_TICK, 32'sh0, 24'h0, 32'sh0, 1, 32'sh5, 0);
        add_row(prs_pkg::REQ_SLEW, 32'shFFFF_0000, 24'h0, 32'sh7FFF_FFFF, 1, 32'sh5, 1);
        add_row(prs_pkg::REQ_TICK, 32'sh0, 24'h0, 32'sh0, 0, '0, 0);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[i]) begin
            send_request(stim_rows[i].req, stim_rows[i].target, stim_rows[i].count,
                         stim_rows[i].step, stim_rows[i].typed, stim_rows[i].exp_value,
                         stim_rows[i].exp_moving);
        end

        run_random_phase(330);
        idle_pct = 52;
        run_random_phase(330);
        idle_pct = 0;
        stall_pct = 52;
        run_random_phase(330);
        idle_pct = 38;
        stall_pct = 38;
        run_random_phase(330);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        drain_cycles = 0;
        while (pending_levels.size() != 0 && drain_cycles < 5000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (60) @(posedge i_clk);
        if (pending_levels.size() != 0) begin
            $error("%0d expected result items never arrived", pending_levels.size());
            error_count++;
        end

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
